// File: src/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the cuckoo hash lookup table
// Field widths, operation codes, the hash multiplier table and the request
// that starts one bucket-index computation.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int KEY_W     = 28;
	localparam int VAL_W     = 32;
	localparam int ENTRY_W   = KEY_W + VAL_W;
	localparam int CNT_OUT_W = 10;
	localparam int CHOICE_W  = 3;

	localparam logic [CNT_OUT_W-1:0] COUNT_SAT = 10'd1023;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef struct packed {
		logic                start;
		logic [KEY_W-1:0]    key;
		logic [CHOICE_W-1:0] choice;
	} hash_req_t;

	function automatic logic [4:0] hash_mult(input logic [CHOICE_W-1:0] choice);
		logic [4:0] m;
		case (choice)
			3'd0:    m = 5'd23;
			3'd1:    m = 5'd19;
			3'd2:    m = 5'd3;
			3'd3:    m = 5'd5;
			3'd4:    m = 5'd7;
			3'd5:    m = 5'd11;
			3'd6:    m = 5'd13;
			default: m = 5'd17;
		endcase
		return m;
	endfunction

endpackage

// File: src/cuckoo_hash_lookup_table.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_lookup_table: cuckoo hash table with insert and search
// Each probe: index pipeline, one bucket read, one evaluate step with
// write-back of the carried item on insert. One request in flight at a time.
// A rejected request goes straight to the result state; a search probes up to
//   HASH_CHOICES buckets, an insert up to PROBE_ROUNDS*HASH_CHOICES.
// A new request waits until the last one is done; the probe loop through the
//   index pipeline, the single bucket memory and a stalled output set the pace.
// Reset: a sweep over all BUCKETS entries (512 by default) clears the bucket
//   memory; s_tready stays low until it ends.
// ----------------------------------------------------------------------------
module cuckoo_hash_lookup_table #(
	parameter int BUCKETS      = 512,
	parameter int PROBE_ROUNDS = 8,
	parameter int HASH_CHOICES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key [27:0], value [59:28], zero [63:60]
	input  logic        s_tuser,   // mode [0]: 0 insert, 1 search
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // value_out [31:0], occupied_count [41:32], zero [47:42]
	output logic        m_tuser    // ok [0]
);

	import cht_pkg::*;

	localparam int IDX_W = $clog2(BUCKETS);
	localparam int CNT_W = $clog2(BUCKETS + 1);
	localparam int CW    = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
	localparam int CH_W  = (HASH_CHOICES > 1) ? $clog2(HASH_CHOICES) : 1;
	localparam int RND_W = (PROBE_ROUNDS > 1) ? $clog2(PROBE_ROUNDS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_EVAL,
		ST_RESULT
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W-1:0]   idx_q;
	logic               mode_q;
	logic [KEY_W-1:0]   ck_q;
	logic [VAL_W-1:0]   cv_q;
	logic [CH_W-1:0]    choice_q;
	logic [RND_W-1:0]   round_q;
	logic [CNT_W-1:0]   count_q;
	logic               ok_q;
	logic [VAL_W-1:0]   val_q;
	logic               m_tvalid_q;
	logic [47:0]        m_tdata_q;
	logic               m_tuser_q;

	logic [KEY_W-1:0]   in_key;
	logic [VAL_W-1:0]   in_val;
	logic               accept;
	logic               reject;

	hash_req_t          hreq;
	logic               h_valid;
	logic [IDX_W-1:0]   h_idx;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	logic [KEY_W-1:0]   sk;
	logic [VAL_W-1:0]   sv;
	logic               empty;
	logic               key_hit;
	logic               choice_last;
	logic               round_last;
	logic               last_probe;
	logic [CH_W-1:0]    nxt_choice;
	logic               ev_continue;
	logic [CW-1:0]      cnt_ext;
	logic [CNT_OUT_W-1:0] cnt_sat;

	assign in_key   = s_tdata[KEY_W-1:0];
	assign in_val   = s_tdata[ENTRY_W-1:KEY_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign reject   = (in_key == '0) || ((s_tuser == MODE_INSERT) && (in_val == '0));

	assign sk          = ram_rdata[KEY_W-1:0];
	assign sv          = ram_rdata[ENTRY_W-1:KEY_W];
	assign empty       = (sk == '0);
	assign key_hit     = (sk == ck_q);
	assign choice_last = (choice_q == CH_W'(HASH_CHOICES - 1));
	assign round_last  = (round_q == RND_W'(PROBE_ROUNDS - 1));
	assign last_probe  = choice_last && round_last;
	assign nxt_choice  = choice_last ? '0 : CH_W'(choice_q + 1'b1);

	assign ev_continue = (state_q == ST_EVAL) &&
		((mode_q == MODE_INSERT) ? !(empty || key_hit || last_probe)
		                         : !(key_hit || choice_last));

	// start the index pipeline for the first probe or the next one
	always_comb begin
		hreq.start  = 1'b0;
		hreq.key    = in_key;
		hreq.choice = '0;
		if (accept && !reject) begin
			hreq.start = 1'b1;
		end else if (ev_continue) begin
			hreq.start  = 1'b1;
			hreq.key    = (mode_q == MODE_INSERT) ? sk : ck_q;
			hreq.choice = CHOICE_W'(nxt_choice);
		end
	end

	// an insert probe always writes the carried item back to the bucket
	assign ram_we    = (state_q == ST_CLEAR) ||
		((state_q == ST_EVAL) && (mode_q == MODE_INSERT));
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : idx_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : {cv_q, ck_q};

	assign cnt_ext = CW'(count_q);
	assign cnt_sat = (cnt_ext > CW'(COUNT_SAT)) ? COUNT_SAT : cnt_ext[CNT_OUT_W-1:0];

	cht_hash #(
		.BUCKETS(BUCKETS)
	) u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (hreq),
		.idx_valid(h_valid),
		.idx      (h_idx)
	);

	cht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(BUCKETS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (h_valid),
		.raddr(h_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			idx_q      <= '0;
			mode_q     <= MODE_INSERT;
			ck_q       <= '0;
			cv_q       <= '0;
			choice_q   <= '0;
			round_q    <= '0;
			count_q    <= '0;
			ok_q       <= 1'b0;
			val_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_RESULT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= IDX_W'(clr_q + 1'b1);
					if (clr_q == IDX_W'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						mode_q   <= s_tuser;
						ck_q     <= in_key;
						cv_q     <= in_val;
						choice_q <= '0;
						round_q  <= '0;
						ok_q     <= 1'b0;
						val_q    <= '0;
						state_q  <= reject ? ST_RESULT : ST_HASH;
					end
				end
				ST_HASH: begin
					if (h_valid) begin
						idx_q   <= h_idx;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (mode_q == MODE_INSERT) begin
						if (empty) begin
							count_q <= CNT_W'(count_q + 1'b1);
							ok_q    <= 1'b1;
							state_q <= ST_RESULT;
						end else if (key_hit) begin
							ok_q    <= 1'b1;
							state_q <= ST_RESULT;
						end else begin
							// carry the evicted item on
							ck_q     <= sk;
							cv_q     <= sv;
							choice_q <= nxt_choice;
							if (choice_last) begin
								round_q <= RND_W'(round_q + 1'b1);
							end
							state_q <= last_probe ? ST_RESULT : ST_HASH;
						end
					end else begin
						if (key_hit) begin
							ok_q    <= 1'b1;
							val_q   <= sv;
							state_q <= ST_RESULT;
						end else if (choice_last) begin
							state_q <= ST_RESULT;
						end else begin
							choice_q <= nxt_choice;
							state_q  <= ST_HASH;
						end
					end
				end
				ST_RESULT: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'b0, cnt_sat, val_q};
						m_tuser_q  <= ok_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(count_q) <= CW'(BUCKETS))
		else $error("occupied count exceeds bucket count");

	a_index_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		h_valid |-> (state_q == ST_HASH))
		else $error("bucket index arrived outside the probe wait");

	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q != ST_CLEAR)) |-> ((state_q == ST_EVAL) && (mode_q == MODE_INSERT)))
		else $error("bucket write outside an insert probe");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_RESULT))
		else $error("result item raised without a finished request");

	a_search_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EVAL) && (mode_q == MODE_SEARCH)) |=> $stable(count_q))
		else $error("search changed the occupied count");
`endif

endmodule

// File: src/cht_ram.sv
// ----------------------------------------------------------------------------
// cht_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/cht_hash.sv
// ----------------------------------------------------------------------------
// cht_hash: bucket index pipeline
// Three stages: key times multiplier (wraps at 32 bits), reciprocal
// quotient estimate, remainder; final compare-subtract gives the index.
// ----------------------------------------------------------------------------
module cht_hash #(
	parameter int BUCKETS = 512
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cht_pkg::hash_req_t         req,
	output logic                       idx_valid,
	output logic [$clog2(BUCKETS)-1:0] idx
);

	import cht_pkg::*;

	localparam int IDX_W = $clog2(BUCKETS);
	localparam logic [32:0] TWO_POW_32 = 33'h1_0000_0000;
	localparam logic [31:0] RECIP = 32'(TWO_POW_32 / 33'(BUCKETS));
	localparam logic [IDX_W:0] BK = (IDX_W + 1)'(BUCKETS);

	logic            v_s1, v_s2, v_s3;
	logic [31:0]     p_s1, p_s2;
	logic [31:0]     qe_s2;
	logic [IDX_W:0]  r_s3;

	logic [31:0]     prod1;
	logic [63:0]     prod2;
	logic [31:0]     qb;
	logic [31:0]     diff;
	logic [IDX_W:0]  r_red;

	assign prod1 = 32'(32'(req.key) * 32'(hash_mult(req.choice)));
	assign prod2 = 64'(p_s1) * 64'(RECIP);
	assign qb    = 32'(qe_s2 * 32'(BUCKETS));
	assign diff  = p_s2 - qb;

	// quotient estimate is low by at most one: one correction step
	assign r_red     = (r_s3 >= BK) ? r_s3 - BK : r_s3;
	assign idx       = r_red[IDX_W-1:0];
	assign idx_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s1  <= prod1;
		p_s2  <= p_s1;
		qe_s2 <= prod2[63:32];
		r_s3  <= diff[IDX_W:0];
	end

endmodule
